@@ hdl/dqsa_pkg.sv @@
// Shared types, constants and helpers for the quad surface area block.
`default_nettype none
package dqsa_pkg;

  localparam int DQSA_ELEV_WIDTH = 32;
  localparam int DQSA_ACC_WIDTH  = 63;

  // Configuration register indexes
  localparam logic [1:0] REG_EW_RES = 2'd0;
  localparam logic [1:0] REG_NS_RES = 2'd1;
  localparam logic [1:0] REG_Z_SCALE = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_GO,
    S_MUL_WAIT,
    S_SQRT_GO,
    S_SQRT_WAIT,
    S_AREA,
    S_FINISH
  } ctrl_state_t;

  // Multiply jobs: operands and destination follow from the code
  typedef enum logic [2:0] {
    OP_NS,   // N * s
    OP_EW,   // E * s
    OP_EN,   // E * N >> 16
    OP_C1,   // ns_s * da >> 24
    OP_C2,   // ew_s * db >> 24
    OP_SQ1,  // c1^2
    OP_SQ2,  // + c2^2
    OP_SQ3   // + en^2
  } mul_op_t;

  typedef struct packed {
    logic       load_item;
    logic       mul_start;
    mul_op_t    mul_op;
    logic       sqrt_start;
    logic       area_load;
    logic [1:0] tri_idx;
    logic       finish;
  } dqsa_cmd_t;

  typedef struct packed {
    logic quad_ok;
    logic mul_done;
    logic sqrt_done;
    logic out_free;
  } dqsa_status_t;

  // Saturating add, capped at cap_max
  function automatic logic [63:0] cap_add(input logic [63:0] a, input logic [63:0] b,
                                          input logic [63:0] cap_max);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > {1'b0, cap_max}) ? cap_max : s[63:0];
  endfunction

endpackage
`default_nettype wire

@@ hdl/dqsa_ctrl.sv @@
// Sequencer for the quad surface area block.
`default_nettype none
module dqsa_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire dqsa_pkg::dqsa_status_t sts,
  output dqsa_pkg::dqsa_cmd_t         cmd
);
  import dqsa_pkg::*;

  ctrl_state_t state_r, state_nxt;
  mul_op_t     op_r, op_nxt;
  logic [1:0]  tri_r, tri_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_r    <= OP_NS;
      tri_r   <= 2'd0;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      tri_r   <= tri_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    tri_nxt   = tri_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt    = OP_NS;
          tri_nxt   = 2'd0;
          state_nxt = sts.quad_ok ? S_MUL_GO : S_FINISH;
        end
      end
      S_MUL_GO: state_nxt = S_MUL_WAIT;
      S_MUL_WAIT: begin
        if (sts.mul_done) begin
          case (op_r)
            OP_NS:   begin op_nxt = OP_EW;  state_nxt = S_MUL_GO; end
            OP_EW:   begin op_nxt = OP_EN;  state_nxt = S_MUL_GO; end
            OP_EN:   begin op_nxt = OP_C1;  state_nxt = S_MUL_GO; end
            OP_C1:   begin op_nxt = OP_C2;  state_nxt = S_MUL_GO; end
            OP_C2:   begin op_nxt = OP_SQ1; state_nxt = S_MUL_GO; end
            OP_SQ1:  begin op_nxt = OP_SQ2; state_nxt = S_MUL_GO; end
            OP_SQ2:  begin op_nxt = OP_SQ3; state_nxt = S_MUL_GO; end
            default: state_nxt = S_SQRT_GO;
          endcase
        end
      end
      S_SQRT_GO: state_nxt = S_SQRT_WAIT;
      S_SQRT_WAIT: begin
        if (sts.sqrt_done) state_nxt = S_AREA;
      end
      S_AREA: begin
        if (tri_r == 2'd3) begin
          state_nxt = S_FINISH;
        end else begin
          tri_nxt   = tri_r + 2'd1;
          op_nxt    = OP_C1;
          state_nxt = S_MUL_GO;
        end
      end
      S_FINISH: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_tready      = (state_r == S_IDLE);
    cmd            = '0;
    cmd.mul_op     = op_r;
    cmd.tri_idx    = tri_r;
    cmd.load_item  = (state_r == S_IDLE) && in_tvalid;
    cmd.mul_start  = (state_r == S_MUL_GO);
    cmd.sqrt_start = (state_r == S_SQRT_GO);
    cmd.area_load  = (state_r == S_AREA);
    cmd.finish     = (state_r == S_FINISH) && sts.out_free;
  end

endmodule
`default_nettype wire

@@ hdl/dqsa_dp.sv @@
// Datapath: config, column history, shared multiplier, root unit, sums, output item.
`default_nettype none
module dqsa_dp #(
  parameter int ELEV_WIDTH = dqsa_pkg::DQSA_ELEV_WIDTH,
  parameter int ACC_WIDTH  = dqsa_pkg::DQSA_ACC_WIDTH
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_we,
  input  wire logic [1:0]             cfg_addr,
  input  wire logic [31:0]            cfg_wdata,
  input  wire logic [63:0]            in_tdata,
  input  wire logic [3:0]             in_tuser,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [127:0]                out_tdata,
  output logic [1:0]                  out_tuser,
  input  wire dqsa_pkg::dqsa_cmd_t    cmd,
  output dqsa_pkg::dqsa_status_t      sts
);
  import dqsa_pkg::*;

  localparam int DW = ELEV_WIDTH + 1;
  localparam logic [63:0] ACC_MAX = (64'd1 << ACC_WIDTH) - 64'd1;

  function automatic logic [DW-1:0] mag(input logic signed [ELEV_WIDTH-1:0] x,
                                        input logic signed [ELEV_WIDTH-1:0] y);
    logic signed [DW-1:0] d;
    d = DW'(x) - DW'(y);
    return d[DW-1] ? DW'(-d) : d;
  endfunction

  // Configuration
  logic [31:0] ew_res_r, ns_res_r, z_scale_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ew_res_r  <= 32'd65536;
      ns_res_r  <= 32'd65536;
      z_scale_r <= 32'd65536;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_EW_RES:  ew_res_r  <= cfg_wdata;
        REG_NS_RES:  ns_res_r  <= cfg_wdata;
        REG_Z_SCALE: z_scale_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input fields; elevations taken as two's complement in their low ELEV_WIDTH bits
  logic [63:0] top_ext, bot_ext;
  logic signed [ELEV_WIDTH-1:0] cur_top, cur_bot;
  logic cur_top_null, cur_bot_null, first_in_row, clear_sums;
  assign top_ext      = {32'd0, in_tdata[31:0]};
  assign bot_ext      = {32'd0, in_tdata[63:32]};
  assign cur_top      = top_ext[ELEV_WIDTH-1:0];
  assign cur_bot      = bot_ext[ELEV_WIDTH-1:0];
  assign cur_top_null = in_tuser[0];
  assign cur_bot_null = in_tuser[1];
  assign first_in_row = in_tuser[2];
  assign clear_sums   = in_tuser[3];

  logic signed [ELEV_WIDTH-1:0] prev_top_r, prev_bot_r;
  logic prev_top_null_r, prev_bot_null_r;
  logic quad_ok;
  assign quad_ok = !first_in_row && !cur_top_null && !cur_bot_null &&
                   !prev_top_null_r && !prev_bot_null_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_top_r      <= '0;
      prev_bot_r      <= '0;
      prev_top_null_r <= 1'b1;
      prev_bot_null_r <= 1'b1;
    end else if (cmd.load_item) begin
      prev_top_r      <= cur_top;
      prev_bot_r      <= cur_bot;
      prev_top_null_r <= cur_top_null;
      prev_bot_null_r <= cur_bot_null;
    end
  end

  // Per-item edge magnitudes
  logic [DW-1:0] d_top_r, d_bot_r, d_cur_r, d_prv_r;
  logic          clr_r, added_r;
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      d_top_r <= mag(cur_top, prev_top_r);
      d_bot_r <= mag(prev_bot_r, cur_bot);
      d_cur_r <= mag(cur_top, cur_bot);
      d_prv_r <= mag(prev_top_r, prev_bot_r);
      clr_r   <= clear_sums;
      added_r <= quad_ok;
    end
  end

  logic [DW-1:0] da, db;
  assign da = cmd.tri_idx[0] ? d_bot_r : d_top_r;
  assign db = (cmd.tri_idx == 2'd0 || cmd.tri_idx == 2'd3) ? d_cur_r : d_prv_r;

  // Shared 32x32 multiplier, four partial products per 64x64 job
  logic [63:0]  ns_s_r, ew_s_r, c1_r, c2_r;
  logic [47:0]  en_r;
  logic [127:0] sq_r;
  logic         ovf_r;
  mul_op_t      mop_r;
  logic         mbusy_r;
  logic [2:0]   mcnt_r;
  logic [1:0]   mps_r;
  logic [63:0]  mprod_r;
  logic [127:0] macc_r, mshift, macc_nxt;
  logic [63:0]  opa, opb;
  logic [31:0]  pa, pb;

  always_comb begin
    case (mop_r)
      OP_NS:   begin opa = {32'd0, ns_res_r}; opb = {32'd0, z_scale_r}; end
      OP_EW:   begin opa = {32'd0, ew_res_r}; opb = {32'd0, z_scale_r}; end
      OP_EN:   begin opa = {32'd0, ew_res_r}; opb = {32'd0, ns_res_r}; end
      OP_C1:   begin opa = ns_s_r; opb = {{(64-DW){1'b0}}, da}; end
      OP_C2:   begin opa = ew_s_r; opb = {{(64-DW){1'b0}}, db}; end
      OP_SQ1:  begin opa = c1_r; opb = c1_r; end
      OP_SQ2:  begin opa = c2_r; opb = c2_r; end
      default: begin opa = {16'd0, en_r}; opb = {16'd0, en_r}; end
    endcase
    pa = mcnt_r[1] ? opa[63:32] : opa[31:0];
    pb = mcnt_r[0] ? opb[63:32] : opb[31:0];
    case (mps_r)
      2'd0:    mshift = {64'd0, mprod_r};
      2'd3:    mshift = {mprod_r, 64'd0};
      default: mshift = {32'd0, mprod_r, 32'd0};
    endcase
    macc_nxt = macc_r + mshift;
  end

  logic mul_done;
  assign mul_done = mbusy_r && (mcnt_r == 3'd4);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mbusy_r <= 1'b0;
    end else if (cmd.mul_start) begin
      mbusy_r <= 1'b1;
    end else if (mul_done) begin
      mbusy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_start) begin
      mop_r  <= cmd.mul_op;
      mcnt_r <= 3'd0;
      macc_r <= '0;
    end else if (mbusy_r) begin
      mcnt_r  <= mcnt_r + 3'd1;
      mprod_r <= pa * pb;
      mps_r   <= mcnt_r[1:0];
      if (mcnt_r != 3'd0) macc_r <= macc_nxt;
    end
    if (mul_done) begin
      case (mop_r)
        OP_NS:  ns_s_r <= macc_nxt[63:0];
        OP_EW:  ew_s_r <= macc_nxt[63:0];
        OP_EN:  en_r   <= macc_nxt[63:16];
        OP_C1: begin
          c1_r  <= {1'b0, macc_nxt[86:24]};
          ovf_r <= (macc_nxt[127:87] != '0);
        end
        OP_C2: begin
          c2_r  <= {1'b0, macc_nxt[86:24]};
          ovf_r <= ovf_r || (macc_nxt[127:87] != '0);
        end
        OP_SQ1:  sq_r <= macc_nxt;
        default: sq_r <= sq_r + macc_nxt;
      endcase
    end
  end

  // Restoring square root, one result bit per cycle
  logic         sbusy_r;
  logic [5:0]   scnt_r;
  logic [127:0] rad_r;
  logic [65:0]  rem_r;
  logic [63:0]  root_r;
  logic [67:0]  rem_sh, trial;
  logic         sqrt_done;
  assign rem_sh    = {rem_r, rad_r[127:126]};
  assign trial     = {2'b00, root_r, 2'b01};
  assign sqrt_done = sbusy_r && (scnt_r == 6'd63);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sbusy_r <= 1'b0;
    end else if (cmd.sqrt_start) begin
      sbusy_r <= 1'b1;
    end else if (sqrt_done) begin
      sbusy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sqrt_start) begin
      rad_r  <= sq_r;
      rem_r  <= '0;
      root_r <= '0;
      scnt_r <= 6'd0;
    end else if (sbusy_r) begin
      rad_r  <= {rad_r[125:0], 2'b00};
      scnt_r <= scnt_r + 6'd1;
      if (rem_sh >= trial) begin
        rem_r  <= 66'(rem_sh - trial);
        root_r <= {root_r[62:0], 1'b1};
      end else begin
        rem_r  <= rem_sh[65:0];
        root_r <= {root_r[62:0], 1'b0};
      end
    end
  end

  // Triangle areas into split totals
  logic [63:0] area, g1_r, g2_r;
  assign area = ovf_r ? ACC_MAX : {1'b0, root_r[63:1]};

  always_ff @(posedge clk) begin
    if (cmd.area_load) begin
      case (cmd.tri_idx)
        2'd0:    g1_r <= area;
        2'd1:    g1_r <= cap_add(g1_r, area, ACC_MAX);
        2'd2:    g2_r <= area;
        default: g2_r <= cap_add(g2_r, area, ACC_MAX);
      endcase
    end
  end

  // Running sums and the output item
  logic [ACC_WIDTH-1:0] low_r, high_r;
  logic                 sat_r;
  logic [63:0] base_lo, base_hi, g_lo, g_hi, new_lo, new_hi;
  logic        base_sat, new_sat;
  always_comb begin
    base_lo  = clr_r ? 64'd0 : 64'(low_r);
    base_hi  = clr_r ? 64'd0 : 64'(high_r);
    base_sat = clr_r ? 1'b0 : sat_r;
    g_lo     = (g1_r < g2_r) ? g1_r : g2_r;
    g_hi     = (g1_r < g2_r) ? g2_r : g1_r;
    new_lo   = added_r ? cap_add(base_lo, g_lo, ACC_MAX) : base_lo;
    new_hi   = added_r ? cap_add(base_hi, g_hi, ACC_MAX) : base_hi;
    new_sat  = base_sat || (added_r && (new_lo == ACC_MAX || new_hi == ACC_MAX));
  end

  logic out_valid_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r       <= '0;
      high_r      <= '0;
      sat_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.finish) begin
        low_r       <= new_lo[ACC_WIDTH-1:0];
        high_r      <= new_hi[ACC_WIDTH-1:0];
        sat_r       <= new_sat;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  logic [62:0] out_lo_r, out_hi_r;
  logic        out_add_r, out_sat_r;
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_lo_r  <= 63'(new_lo[ACC_WIDTH-1:0]);
      out_hi_r  <= 63'(new_hi[ACC_WIDTH-1:0]);
      out_add_r <= added_r;
      out_sat_r <= new_sat;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_hi_r, out_lo_r};
  assign out_tuser  = {out_sat_r, out_add_r};

  always_comb begin
    sts.quad_ok   = quad_ok;
    sts.mul_done  = mul_done;
    sts.sqrt_done = sqrt_done;
    sts.out_free  = !out_valid_r || out_tready;
  end

endmodule
`default_nettype wire

@@ hdl/dem_quad_surface_area_unit.sv @@
// Top level of the triangulated elevation surface area unit.
// Usage:
//  - Input channel (in_*): one item per raster column, upper and lower
//    elevation (Q24.8) in tdata, null marks, first-in-row and clear flags
//    in tuser.
//  - Output channel (out_*): one item per input item, with the running low
//    and high area sums (Q47.16), a quad-added flag and a saturation flag.
//  - Config port (cfg_*): cell width, cell height and z scale (Q16.16); the user
//    must write them only while no item is in flight; the block does not enforce this.
// Flow: one item at a time. A column that forms a quad runs three setup
// products, then per triangle five 64x64 products on one shared 32x32
// multiplier and a 64-step square root. A column that forms no quad goes
// straight from idle to the sum update. in_tready is high only while the
// sequencer is idle.
// Reset: sums and saturation clear, the kept column reads as null, the
// registers return to 1.0.
// Stall: the result sits in an output register; a new item can be accepted
// while it waits, and the next result waits until the slot frees.
`default_nettype none
module dem_quad_surface_area_unit #(
  parameter int ELEV_WIDTH = dqsa_pkg::DQSA_ELEV_WIDTH,
  parameter int ACC_WIDTH  = dqsa_pkg::DQSA_ACC_WIDTH
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_addr,
  input  wire logic [31:0]  cfg_wdata,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [63:0]  in_tdata,   // top_elev, bottom_elev
  input  wire logic [3:0]   in_tuser,   // top_is_null, bottom_is_null, first_in_row, clear_sums
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [127:0]      out_tdata,  // low_sum, high_sum, zero fill
  output logic [1:0]        out_tuser   // quad_added, saturated
);
  import dqsa_pkg::*;

  dqsa_cmd_t    cmd;
  dqsa_status_t sts;

  // Sequencer: for a quad walks setup products and four triangles, then the sum update
  dqsa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  dqsa_dp #(
    .ELEV_WIDTH (ELEV_WIDTH),
    .ACC_WIDTH  (ACC_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule
`default_nettype wire
